// ===== rtl/ps2_pointer_packet_decoder_defines.svh =====
// Assertion macros shared by the pointer decoder RTL.
// No dependencies; each file that asserts includes this header.
`ifndef PS2_POINTER_PACKET_DECODER_DEFINES_SVH
`define PS2_POINTER_PACKET_DECODER_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define PPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PPD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/ppd_pkg.sv =====
// Shared types and constants for the pointer packet decoder.
// No dependencies; imported by every module of the block.
package ppd_pkg;

	localparam int TickW     = 32;
	localparam int QDepth    = 2;
	localparam int QAw       = $clog2(QDepth);
	localparam int QCw       = $clog2(QDepth + 1);
	localparam int PktMax    = 6;
	localparam int StoreN    = PktMax - 1;

	localparam logic [2:0] SizePlain = 3'd3;
	localparam logic [2:0] SizeAbs   = 3'd6;
	localparam int         SyncBit   = 3;

	typedef enum logic [2:0] {
		REG_ENABLE     = 3'd0,
		REG_ABS_MODE   = 3'd1,
		REG_TAP_TICKS  = 3'd2,
		REG_TAP_MOVE   = 3'd3,
		REG_SENS_SHIFT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        enable;
		logic        abs_mode;
		logic [7:0]  tap_ticks;
		logic [12:0] tap_move;
		logic [2:0]  sens_shift;
	} cfg_t;

	// One framed packet as handed from the front to the back.
	typedef struct packed {
		logic [PktMax-1:0][7:0] b;
		logic [TickW-1:0]       tick;
	} pkt_t;

endpackage

// ===== rtl/ppd_front.sv =====
// Byte framer: syncs on bit 3 of the first byte and assembles packets.
// Depends on ppd_pkg; feeds ppd_queue.
module ppd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  ppd_pkg::cfg_t       cfg,
	input  logic                byte_accept,
	input  logic [7:0]          aux_byte,
	input  logic [ppd_pkg::TickW-1:0] tick_now,
	output logic                push,
	output ppd_pkg::pkt_t       push_pkt
);
	import ppd_pkg::*;

	logic [2:0] byte_count_q;
	logic [7:0] packet_bytes_q [StoreN];
	logic [2:0] size;
	logic       taken;
	logic       last;

	assign size  = cfg.abs_mode ? SizeAbs : SizePlain;
	// drop a first byte that lacks the sync bit
	assign taken = byte_accept && cfg.enable &&
		!(byte_count_q == 3'd0 && !aux_byte[SyncBit]);
	assign last  = (byte_count_q + 3'd1) >= size;
	assign push  = taken && last;

	always_comb begin
		for (int i = 0; i < StoreN; i++) begin
			push_pkt.b[i] = (3'(i) == size - 3'd1) ? aux_byte : packet_bytes_q[i];
		end
		push_pkt.b[PktMax-1] = aux_byte;
		push_pkt.tick        = tick_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 3'd0;
		end else if (taken) begin
			byte_count_q <= last ? 3'd0 : byte_count_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (taken && !last) begin
			packet_bytes_q[byte_count_q] <= aux_byte;
		end
	end

endmodule

// ===== rtl/ppd_queue.sv =====
// Two-entry packet queue between the framer and the decoder.
// Depends on ppd_pkg and the shared assertion macros.
`include "ps2_pointer_packet_decoder_defines.svh"

module ppd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ppd_pkg::pkt_t push_pkt,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output ppd_pkg::pkt_t head
);
	import ppd_pkg::*;

	pkt_t           slots_q [QDepth];
	logic [QAw-1:0] wr_ptr_q;
	logic [QAw-1:0] rd_ptr_q;
	logic [QCw-1:0] count_q;

	assign full  = count_q == QCw'(QDepth);
	assign empty = count_q == '0;
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAw'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAw'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCw'(1);
				2'b01:   count_q <= count_q - QCw'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_pkt;
		end
	end

	`PPD_ASSERT(a_count_bound, count_q <= QCw'(QDepth), "queue count past depth")
	`PPD_ASSERT(a_no_push_full, push |-> !full, "push into a full queue")
	`PPD_ASSERT(a_no_pop_empty, pop |-> !empty, "pop from an empty queue")
	`PPD_ASSERT(a_count_up, (push && !pop) |=> count_q == $past(count_q) + QCw'(1),
		"count did not advance on push")

endmodule

// ===== rtl/ppd_back.sv =====
// Packet decoder: plain and absolute decode, touch tracking, tap click.
// Depends on ppd_pkg; drains ppd_queue into the output register.
module ppd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ppd_pkg::cfg_t cfg,
	input  logic          empty,
	input  ppd_pkg::pkt_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          button_left,
	output logic          button_right,
	output logic          button_middle,
	output logic signed [13:0] delta_x,
	output logic signed [13:0] delta_y
);
	import ppd_pkg::*;

	logic              touch_active_q;
	logic [12:0]       prev_x_q, prev_y_q, start_x_q, start_y_q;
	logic [TickW-1:0]  start_tick_q;
	logic              middle_q;
	logic              out_valid_q;
	logic              left_q, right_q;
	logic signed [13:0] dx_q, dy_q;

	logic [12:0]        pos_x, pos_y;
	logic signed [13:0] dpx, dpy, dsx, dsy, shx, shy;
	logic [13:0]        absx, absy;
	logic [TickW-1:0]   held;
	logic               tap;
	logic               touching;
	logic               left_n, middle_n;
	logic signed [13:0] dx_n, dy_n;

	assign pop = !empty && (!out_valid_q || !out_stall);

	assign pos_x = {head.b[3][4], head.b[1][3:0], head.b[4]};
	assign pos_y = {head.b[3][5], head.b[1][7:4], head.b[5]};
	assign dpx   = $signed({1'b0, pos_x}) - $signed({1'b0, prev_x_q});
	assign dpy   = $signed({1'b0, pos_y}) - $signed({1'b0, prev_y_q});
	assign shx   = dpx >>> cfg.sens_shift;
	assign shy   = dpy >>> cfg.sens_shift;
	assign dsx   = $signed({1'b0, pos_x}) - $signed({1'b0, start_x_q});
	assign dsy   = $signed({1'b0, pos_y}) - $signed({1'b0, start_y_q});
	assign absx  = dsx[13] ? 14'(-dsx) : 14'(dsx);
	assign absy  = dsy[13] ? 14'(-dsy) : 14'(dsy);
	assign held  = head.tick - start_tick_q;
	assign touching = head.b[2] != 8'd0;
	assign tap   = !touching && touch_active_q &&
		held <= TickW'(cfg.tap_ticks) &&
		absx < {1'b0, cfg.tap_move} && absy < {1'b0, cfg.tap_move};

	always_comb begin
		left_n   = head.b[0][0];
		middle_n = middle_q;
		dx_n     = '0;
		dy_n     = '0;
		if (!cfg.abs_mode) begin
			middle_n = head.b[0][2];
			dx_n     = {{5{head.b[0][4]}}, head.b[0][4], head.b[1]};
			dy_n     = {{5{head.b[0][5]}}, head.b[0][5], head.b[2]};
		end else begin
			left_n = head.b[0][0] | tap;
			// moving touch only; start, release and idle give no motion
			if (touching && touch_active_q) begin
				dx_n = shx;
				dy_n = -shy;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_active_q <= 1'b0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			start_x_q      <= '0;
			start_y_q      <= '0;
			start_tick_q   <= '0;
			middle_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				middle_q    <= middle_n;
				if (cfg.abs_mode) begin
					if (touching) begin
						prev_x_q <= pos_x;
						prev_y_q <= pos_y;
						if (!touch_active_q) begin
							touch_active_q <= 1'b1;
							start_tick_q   <= head.tick;
							start_x_q      <= pos_x;
							start_y_q      <= pos_y;
						end
					end else begin
						touch_active_q <= 1'b0;
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			left_q  <= left_n;
			right_q <= head.b[0][1];
			dx_q    <= dx_n;
			dy_q    <= dy_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign button_left   = left_q;
	assign button_right  = right_q;
	assign button_middle = middle_q;
	assign delta_x       = dx_q;
	assign delta_y       = dy_q;

endmodule

// ===== rtl/ps2_pointer_packet_decoder.sv =====
// Top level of the PS/2 pointer packet decoder: config registers and wiring.
// Depends on ppd_pkg, ppd_front, ppd_queue and ppd_back.

// Takes one AUX byte per clock cycle, while in_stall is low, with its tick
// count and emits one result per completed packet (three bytes plain, six
// bytes absolute). The framer accepts a byte in every cycle that in_stall is
// low; a completed packet enters a two-entry queue and the decoder pops it
// into the registered result outputs whenever the output is not stalled.
// in_stall rises only when both queue entries are held behind a stalled
// output. Config writes are taken every cycle (cfg_ready is always high) and
// belong in idle periods; unknown register indexes are ignored.
module ps2_pointer_packet_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  aux_byte,
	input  logic [ppd_pkg::TickW-1:0] tick_now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        button_left,
	output logic        button_right,
	output logic        button_middle,
	output logic signed [13:0] delta_x,
	output logic signed [13:0] delta_y,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import ppd_pkg::*;

	cfg_t cfg_q;
	logic push, pop, full, empty;
	pkt_t push_pkt, head;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable     <= 1'b0;
			cfg_q.abs_mode   <= 1'b0;
			cfg_q.tap_ticks  <= 8'd25;
			cfg_q.tap_move   <= 13'd100;
			cfg_q.sens_shift <= 3'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE:     cfg_q.enable     <= cfg_data[0];
				REG_ABS_MODE:   cfg_q.abs_mode   <= cfg_data[0];
				REG_TAP_TICKS:  cfg_q.tap_ticks  <= cfg_data[7:0];
				REG_TAP_MOVE:   cfg_q.tap_move   <= cfg_data;
				REG_SENS_SHIFT: cfg_q.sens_shift <= cfg_data[2:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	ppd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.byte_accept (in_valid && !in_stall),
		.aux_byte    (aux_byte),
		.tick_now    (tick_now),
		.push        (push),
		.push_pkt    (push_pkt)
	);

	ppd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pkt (push_pkt),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	ppd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.empty         (empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.button_left   (button_left),
		.button_right  (button_right),
		.button_middle (button_middle),
		.delta_x       (delta_x),
		.delta_y       (delta_y)
	);

endmodule
